/* rtl/aar_pkg.sv */
`default_nettype none

package aar_pkg;

  // Defaults for the top-level parameters
  localparam int AXIS_WIDTH_DEF  = 16;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 14;

  // Internal fixed point: Q.30
  localparam int QI = 30;

  // CORDIC sin/cos
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  // Arctangent per step, in phase units (2^32 is a full turn)
  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
  };

  // Datapath widths
  localparam int VW = 32;  // cos, sin, unit axis, rounded products
  localparam int MW = 32;  // normalized axis magnitude
  localparam int SW = 64;  // sum of squares
  localparam int RW = 32;  // square root
  localparam int QW = 31;  // unit-axis magnitude quotient

  // Per-item control that rides along the axis path
  typedef struct packed {
    logic                 zero;
    logic [2:0]           neg;
    logic signed [VW-1:0] c;
    logic signed [VW-1:0] s;
  } aar_ctl_t;

  // Side data through the square-root pipeline
  typedef struct packed {
    aar_ctl_t             ctl;
    logic [2:0][MW-1:0]   mag;
  } aar_sq_side_t;

endpackage

`default_nettype wire

/* rtl/aar_cordic.sv */
`default_nettype none

// Rotation-mode CORDIC, one step per stage, plus a quadrant map stage.
module aar_cordic #(
  parameter int ANGLE_WIDTH = aar_pkg::ANGLE_WIDTH_DEF,
  parameter int SIDE_W      = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [ANGLE_WIDTH-1:0]      angle_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic signed [aar_pkg::VW-1:0] cos_o,
  output logic signed [aar_pkg::VW-1:0] sin_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int N  = aar_pkg::CORDIC_STEPS;
  localparam int CW = aar_pkg::CW;
  localparam int VW = aar_pkg::VW;
  localparam logic signed [CW-1:0] ONE = CW'(64'sd1 <<< aar_pkg::QI);

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_e;

  logic [31:0]          phase;
  logic                 vld_in  [N];
  logic signed [CW-1:0] x_in    [N];
  logic signed [CW-1:0] y_in    [N];
  logic signed [CW-1:0] z_in    [N];
  quad_e                quad_in [N];
  logic [SIDE_W-1:0]    side_in [N];
  logic                 vld_q   [N];
  logic signed [CW-1:0] x_q     [N];
  logic signed [CW-1:0] y_q     [N];
  logic signed [CW-1:0] z_q     [N];
  quad_e                quad_q  [N];
  logic [SIDE_W-1:0]    side_q  [N];

  // Angle into a 32-bit phase: top two bits pick the quadrant
  assign phase = {angle_i, {(32-ANGLE_WIDTH){1'b0}}};

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [CW-1:0] x_d, y_d, z_d;

    if (i == 0) begin : g_head
      assign vld_in[i]  = valid_i;
      assign x_in[i]    = aar_pkg::CORDIC_X0;
      assign y_in[i]    = '0;
      assign z_in[i]    = $signed({{(CW-30){1'b0}}, phase[29:0]});
      assign quad_in[i] = quad_e'(phase[31:30]);
      assign side_in[i] = side_i;
    end else begin : g_body
      assign vld_in[i]  = vld_q[i-1];
      assign x_in[i]    = x_q[i-1];
      assign y_in[i]    = y_q[i-1];
      assign z_in[i]    = z_q[i-1];
      assign quad_in[i] = quad_q[i-1];
      assign side_in[i] = side_q[i-1];
    end

    // Micro-rotation toward z = 0
    always_comb begin
      if (!z_in[i][CW-1]) begin
        x_d = x_in[i] - (y_in[i] >>> i);
        y_d = y_in[i] + (x_in[i] >>> i);
        z_d = z_in[i] - $signed({{(CW-30){1'b0}}, aar_pkg::ATAN_TAB[i]});
      end else begin
        x_d = x_in[i] + (y_in[i] >>> i);
        y_d = y_in[i] - (x_in[i] >>> i);
        z_d = z_in[i] + $signed({{(CW-30){1'b0}}, aar_pkg::ATAN_TAB[i]});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i]    <= x_d;
      y_q[i]    <= y_d;
      z_q[i]    <= z_d;
      quad_q[i] <= quad_in[i];
      side_q[i] <= side_in[i];
    end
  end

  // Clamp to +/-1 and map the quadrant
  logic signed [CW-1:0] cc, ss;
  logic signed [VW-1:0] c32, s32, cos_d, sin_d, cos_q, sin_q;
  logic                 vld_out_q;
  logic [SIDE_W-1:0]    side_out_q;

  always_comb begin
    cc = x_q[N-1];
    if (cc > ONE) begin
      cc = ONE;
    end else if (cc < -ONE) begin
      cc = -ONE;
    end
    ss = y_q[N-1];
    if (ss > ONE) begin
      ss = ONE;
    end else if (ss < -ONE) begin
      ss = -ONE;
    end
    c32 = VW'(cc);
    s32 = VW'(ss);
    unique case (quad_q[N-1])
      QUAD_0: begin
        cos_d = c32;
        sin_d = s32;
      end
      QUAD_1: begin
        cos_d = -s32;
        sin_d = c32;
      end
      QUAD_2: begin
        cos_d = -c32;
        sin_d = -s32;
      end
      QUAD_3: begin
        cos_d = s32;
        sin_d = -c32;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q      <= cos_d;
    sin_q      <= sin_d;
    side_out_q <= side_q[N-1];
  end

  assign valid_o = vld_out_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign side_o  = side_out_q;

endmodule

`default_nettype wire

/* rtl/aar_isqrt.sv */
`default_nettype none

// Floor square root of a 64-bit value, one result bit per stage.
module aar_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [aar_pkg::SW-1:0]    rad_i,
  input  aar_pkg::aar_sq_side_t     side_i,
  output logic                      valid_o,
  output logic [aar_pkg::RW-1:0]    root_o,
  output aar_pkg::aar_sq_side_t     side_o
);

  localparam int N  = aar_pkg::RW;
  localparam int SW = aar_pkg::SW;
  localparam int EW = N + 2;  // remainder width

  logic                  vld_in  [N];
  logic [EW-1:0]         rem_in  [N];
  logic [N-1:0]          root_in [N];
  logic [SW-1:0]         rad_in  [N];
  aar_pkg::aar_sq_side_t side_in [N];
  logic                  vld_q   [N];
  logic [EW-1:0]         rem_q   [N];
  logic [N-1:0]          root_q  [N];
  logic [SW-1:0]         rad_q   [N];
  aar_pkg::aar_sq_side_t side_q  [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [EW+1:0] cand;
    logic [EW+1:0] trial;
    logic          take;
    logic [EW-1:0] rem_d;
    logic [N-1:0]  root_d;

    if (i == 0) begin : g_head
      assign vld_in[i]  = valid_i;
      assign rem_in[i]  = '0;
      assign root_in[i] = '0;
      assign rad_in[i]  = rad_i;
      assign side_in[i] = side_i;
    end else begin : g_body
      assign vld_in[i]  = vld_q[i-1];
      assign rem_in[i]  = rem_q[i-1];
      assign root_in[i] = root_q[i-1];
      assign rad_in[i]  = rad_q[i-1];
      assign side_in[i] = side_q[i-1];
    end

    // Bring down two bits, try root*4+1
    always_comb begin
      cand   = {rem_in[i], rad_in[i][SW-1 -: 2]};
      trial  = {2'b00, root_in[i], 2'b01};
      take   = (cand >= trial);
      rem_d  = take ? EW'(cand - trial) : EW'(cand);
      root_d = {root_in[i][N-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= rem_d;
      root_q[i] <= root_d;
      rad_q[i]  <= {rad_in[i][SW-3:0], 2'b00};
      side_q[i] <= side_in[i];
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

`default_nettype wire

/* rtl/aar_div.sv */
`default_nettype none

// Three-lane restoring divider: |u_i| = (mag_i*2^31 + n) / (2n), one bit per stage.
module aar_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [aar_pkg::RW-1:0]          root_i,
  input  logic [2:0][aar_pkg::MW-1:0]     mag_i,
  input  aar_pkg::aar_ctl_t               ctl_i,
  output logic                            valid_o,
  output logic [2:0][aar_pkg::QW-1:0]     quo_o,
  output aar_pkg::aar_ctl_t               ctl_o
);

  localparam int N  = aar_pkg::QW;
  localparam int MW = aar_pkg::MW;
  localparam int DW = aar_pkg::RW + 1;  // divisor 2n and remainder
  localparam int NW = MW + N;           // dividend

  logic [2:0][NW-1:0] dvd;

  logic                 vld_in [N];
  logic [DW-1:0]        dv_in  [N];
  logic [2:0][DW-1:0]   rem_in [N];
  logic [2:0][N-1:0]    low_in [N];
  logic [2:0][N-1:0]    quo_in [N];
  aar_pkg::aar_ctl_t    ctl_in [N];
  logic                 vld_q  [N];
  logic [DW-1:0]        dv_q   [N];
  logic [2:0][DW-1:0]   rem_q  [N];
  logic [2:0][N-1:0]    low_q  [N];
  logic [2:0][N-1:0]    quo_q  [N];
  aar_pkg::aar_ctl_t    ctl_q  [N];

  // Dividend with the rounding term; its top part is already below 2n
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dvd[k] = {mag_i[k], {N{1'b0}}} + NW'(root_i);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [2:0][DW-1:0] rem_d;
    logic [2:0][N-1:0]  quo_d;
    logic [2:0][N-1:0]  low_d;

    if (i == 0) begin : g_head
      assign vld_in[i] = valid_i;
      assign dv_in[i]  = {root_i, 1'b0};
      assign ctl_in[i] = ctl_i;
      assign quo_in[i] = '0;
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign rem_in[i][k] = DW'(dvd[k][NW-1:N]);
        assign low_in[i][k] = dvd[k][N-1:0];
      end
    end else begin : g_body
      assign vld_in[i] = vld_q[i-1];
      assign dv_in[i]  = dv_q[i-1];
      assign ctl_in[i] = ctl_q[i-1];
      assign quo_in[i] = quo_q[i-1];
      assign rem_in[i] = rem_q[i-1];
      assign low_in[i] = low_q[i-1];
    end

    // Shift in one dividend bit per lane, subtract when it fits
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        logic [DW:0] cand;
        logic        take;
        cand     = {rem_in[i][k], low_in[i][k][N-1]};
        take     = (cand >= {1'b0, dv_in[i]});
        rem_d[k] = take ? DW'(cand - {1'b0, dv_in[i]}) : DW'(cand);
        quo_d[k] = {quo_in[i][k][N-2:0], take};
        low_d[k] = {low_in[i][k][N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[i]  <= dv_in[i];
      ctl_q[i] <= ctl_in[i];
      rem_q[i] <= rem_d;
      quo_q[i] <= quo_d;
      low_q[i] <= low_d;
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign ctl_o   = ctl_q[N-1];

endmodule

`default_nettype wire

/* rtl/aar_rod.sv */
`default_nettype none

// Matrix assembly: R = cos*I + sin*[u]x + (1-cos)*u*u^T, five stages.
module aar_rod #(
  parameter int FRAC_BITS = aar_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [2:0][aar_pkg::QW-1:0]   quo_i,
  input  aar_pkg::aar_ctl_t             ctl_i,
  output logic                          valid_o,
  output logic [8:0][FRAC_BITS+1:0]     r_o,
  output logic                          zero_o
);

  localparam int OUT_W = FRAC_BITS + 2;
  localparam int VW    = aar_pkg::VW;
  localparam int QI    = aar_pkg::QI;
  localparam int PW    = 2 * VW;       // u*u, s*u
  localparam int TW    = VW + 1;       // 1 - cos
  localparam int UW    = TW + VW;      // t * uu
  localparam int EW    = 36;           // summed entry
  localparam int SH    = QI - FRAC_BITS;
  localparam logic signed [PW-1:0] HALF_P = PW'(64'sd1 <<< (QI - 1));
  localparam logic signed [UW-1:0] HALF_U = UW'(64'sd1 <<< (QI - 1));
  localparam logic signed [TW-1:0] ONE_T  = TW'(64'sd1 <<< QI);
  localparam logic signed [EW-1:0] LIM    = EW'(64'sd1 <<< FRAC_BITS);

  // Unique products of u*u^T, and which one each entry uses
  localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PB [6] = '{0, 1, 2, 1, 2, 2};
  localparam int PIDX [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};

  // Stage 1: signed unit axis, raw products, 1 - cos
  logic signed [VW-1:0] u [3];
  logic signed [PW-1:0] p1_uu_d [6], p1_uu_q [6];
  logic signed [PW-1:0] p1_su_d [3], p1_su_q [3];
  logic signed [TW-1:0] p1_t_d, p1_t_q;
  logic signed [VW-1:0] p1_c_q;
  logic                 p1_zero_q, p1_vld_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u[k] = ctl_i.neg[k] ? -$signed({1'b0, quo_i[k]}) : $signed({1'b0, quo_i[k]});
    end
    for (int p = 0; p < 6; p++) begin
      p1_uu_d[p] = u[PA[p]] * u[PB[p]];
    end
    for (int k = 0; k < 3; k++) begin
      p1_su_d[k] = ctl_i.s * u[k];
    end
    p1_t_d = ONE_T - TW'(ctl_i.c);
  end

  // Stage 2: round products to Q.30
  logic signed [VW-1:0] p2_uu_d [6], p2_uu_q [6];
  logic signed [VW-1:0] p2_su_d [3], p2_su_q [3];
  logic signed [TW-1:0] p2_t_q;
  logic signed [VW-1:0] p2_c_q;
  logic                 p2_zero_q, p2_vld_q;

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      p2_uu_d[p] = VW'((p1_uu_q[p] + HALF_P) >>> QI);
    end
    for (int k = 0; k < 3; k++) begin
      p2_su_d[k] = VW'((p1_su_q[k] + HALF_P) >>> QI);
    end
  end

  // Stage 3: (1 - cos) * u_i*u_j
  logic signed [UW-1:0] p3_tu_d [6], p3_tu_q [6];
  logic signed [VW-1:0] p3_su_q [3];
  logic signed [VW-1:0] p3_c_q;
  logic                 p3_zero_q, p3_vld_q;

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      p3_tu_d[p] = p2_t_q * p2_uu_q[p];
    end
  end

  // Stage 4: round and add cos on the diagonal, cross terms off it
  logic signed [EW-1:0] base [6];
  logic signed [EW-1:0] sx [3];
  logic signed [EW-1:0] cx;
  logic signed [EW-1:0] p4_e_d [9], p4_e_q [9];
  logic                 p4_zero_q, p4_vld_q;

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      base[p] = EW'((p3_tu_q[p] + HALF_U) >>> QI);
    end
    for (int k = 0; k < 3; k++) begin
      sx[k] = EW'(p3_su_q[k]);
    end
    cx = EW'(p3_c_q);
    for (int e = 0; e < 9; e++) begin
      p4_e_d[e] = base[PIDX[e]];
    end
    p4_e_d[0] = p4_e_d[0] + cx;
    p4_e_d[4] = p4_e_d[4] + cx;
    p4_e_d[8] = p4_e_d[8] + cx;
    p4_e_d[1] = p4_e_d[1] - sx[2];
    p4_e_d[2] = p4_e_d[2] + sx[1];
    p4_e_d[3] = p4_e_d[3] + sx[2];
    p4_e_d[5] = p4_e_d[5] - sx[0];
    p4_e_d[6] = p4_e_d[6] - sx[1];
    p4_e_d[7] = p4_e_d[7] + sx[0];
    // Zero axis: cos times identity
    if (p3_zero_q) begin
      for (int e = 0; e < 9; e++) begin
        p4_e_d[e] = '0;
      end
      p4_e_d[0] = cx;
      p4_e_d[4] = cx;
      p4_e_d[8] = cx;
    end
  end

  // Stage 5: round half up to the output format and clamp to +/-1
  logic signed [EW-1:0]  rnd [9];
  logic [8:0][OUT_W-1:0] p5_r_d, p5_r_q;
  logic                  p5_zero_q, p5_vld_q;

  for (genvar e = 0; e < 9; e++) begin : g_out
    if (SH > 0) begin : g_round
      localparam logic signed [EW-1:0] HALF_O = EW'(64'sd1 <<< (SH - 1));
      assign rnd[e] = (p4_e_q[e] + HALF_O) >>> SH;
    end else begin : g_keep
      assign rnd[e] = p4_e_q[e];
    end

    always_comb begin
      if (rnd[e] > LIM) begin
        p5_r_d[e] = OUT_W'(LIM);
      end else if (rnd[e] < -LIM) begin
        p5_r_d[e] = OUT_W'(-LIM);
      end else begin
        p5_r_d[e] = OUT_W'(rnd[e]);
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= valid_i;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    p1_uu_q   <= p1_uu_d;
    p1_su_q   <= p1_su_d;
    p1_t_q    <= p1_t_d;
    p1_c_q    <= ctl_i.c;
    p1_zero_q <= ctl_i.zero;
    p2_uu_q   <= p2_uu_d;
    p2_su_q   <= p2_su_d;
    p2_t_q    <= p1_t_q;
    p2_c_q    <= p1_c_q;
    p2_zero_q <= p1_zero_q;
    p3_tu_q   <= p3_tu_d;
    p3_su_q   <= p2_su_q;
    p3_c_q    <= p2_c_q;
    p3_zero_q <= p2_zero_q;
    p4_e_q    <= p4_e_d;
    p4_zero_q <= p3_zero_q;
    p5_r_q    <= p5_r_d;
    p5_zero_q <= p4_zero_q;
  end

  assign valid_o = p5_vld_q;
  assign r_o     = p5_r_q;
  assign zero_o  = p5_zero_q;

endmodule

`default_nettype wire

/* rtl/axis_angle_to_rotation_matrix.sv */
// Axis-angle to 3x3 rotation matrix. Takes one item per clock: busy is never
// raised, so an item is taken whenever start is high. Each item comes out on
// valid_o after it has passed through the pipeline stages (CORDIC 31 stages, axis
// normalization 5, square root 32, unit-axis division 31, matrix assembly 5),
// in order, for one cycle; the receiver cannot stall it and must take it then.
// Entries are Q2.FRAC_BITS, row major, clamped to +/-1. An all-zero axis raises
// zero_axis_o and gives cos times identity.
`default_nettype none

module axis_angle_to_rotation_matrix #(
  parameter int AXIS_WIDTH  = aar_pkg::AXIS_WIDTH_DEF,
  parameter int ANGLE_WIDTH = aar_pkg::ANGLE_WIDTH_DEF,
  parameter int FRAC_BITS   = aar_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [AXIS_WIDTH-1:0]  axis_x_i,
  input  logic signed [AXIS_WIDTH-1:0]  axis_y_i,
  input  logic signed [AXIS_WIDTH-1:0]  axis_z_i,
  input  logic signed [ANGLE_WIDTH-1:0] turn_angle_i,
  output logic                          valid_o,
  output logic signed [FRAC_BITS+1:0]   r00_o,
  output logic signed [FRAC_BITS+1:0]   r01_o,
  output logic signed [FRAC_BITS+1:0]   r02_o,
  output logic signed [FRAC_BITS+1:0]   r10_o,
  output logic signed [FRAC_BITS+1:0]   r11_o,
  output logic signed [FRAC_BITS+1:0]   r12_o,
  output logic signed [FRAC_BITS+1:0]   r20_o,
  output logic signed [FRAC_BITS+1:0]   r21_o,
  output logic signed [FRAC_BITS+1:0]   r22_o,
  output logic                          zero_axis_o
);

  localparam int SIDE_W = 3 * AXIS_WIDTH;
  localparam int MW     = aar_pkg::MW;
  localparam int SW     = aar_pkg::SW;
  localparam int VW     = aar_pkg::VW;
  localparam int KW     = 5;
  localparam logic [KW-1:0] KTOP = KW'(aar_pkg::QI);

  // Fully pipelined: never holds off an item
  assign busy = 1'b0;

  // sin/cos, with the axis riding along
  logic                 co_vld;
  logic signed [VW-1:0] co_cos, co_sin;
  logic [SIDE_W-1:0]    co_side;

  aar_cordic #(
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .SIDE_W      (SIDE_W)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .angle_i (turn_angle_i),
    .side_i  ({axis_z_i, axis_y_i, axis_x_i}),
    .valid_o (co_vld),
    .cos_o   (co_cos),
    .sin_o   (co_sin),
    .side_o  (co_side)
  );

  // N1: magnitudes, signs, largest magnitude
  logic signed [AXIS_WIDTH-1:0] ax [3];
  logic signed [MW:0]           ext [3];
  logic [MW-1:0]                n1_mag_d [3], n1_mag_q [3];
  logic [MW-1:0]                n1_max_d, n1_max_q;
  aar_pkg::aar_ctl_t            n1_ctl_d, n1_ctl_q;
  logic                         n1_vld_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax[k]        = co_side[k*AXIS_WIDTH +: AXIS_WIDTH];
      ext[k]       = (MW+1)'(ax[k]);
      n1_mag_d[k]  = ext[k][MW] ? MW'(-ext[k]) : MW'(ext[k]);
      n1_ctl_d.neg[k] = ax[k][AXIS_WIDTH-1];
    end
    n1_max_d = (n1_mag_d[0] > n1_mag_d[1]) ? n1_mag_d[0] : n1_mag_d[1];
    if (n1_mag_d[2] > n1_max_d) begin
      n1_max_d = n1_mag_d[2];
    end
    n1_ctl_d.zero = (n1_max_d == '0);
    n1_ctl_d.c    = co_cos;
    n1_ctl_d.s    = co_sin;
  end

  // N2: shift that brings the largest magnitude to at least 2^30
  logic [KW-1:0]     msb;
  logic [KW-1:0]     n2_k_d, n2_k_q;
  logic [MW-1:0]     n2_mag_q [3];
  aar_pkg::aar_ctl_t n2_ctl_q;
  logic              n2_vld_q;

  always_comb begin
    msb = '0;
    for (int b = 0; b < MW; b++) begin
      if (n1_max_q[b]) begin
        msb = KW'(b);
      end
    end
    n2_k_d = (msb >= KTOP) ? '0 : KTOP - msb;
  end

  // N3: normalize
  logic [MW-1:0]     n3_mag_d [3], n3_mag_q [3];
  aar_pkg::aar_ctl_t n3_ctl_q;
  logic              n3_vld_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n3_mag_d[k] = n2_mag_q[k] << n2_k_q;
    end
  end

  // N4: squares
  logic [SW-1:0]     n4_sq_d [3], n4_sq_q [3];
  logic [MW-1:0]     n4_mag_q [3];
  aar_pkg::aar_ctl_t n4_ctl_q;
  logic              n4_vld_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n4_sq_d[k] = SW'(n3_mag_q[k]) * SW'(n3_mag_q[k]);
    end
  end

  // N5: sum of squares
  logic [SW-1:0]         n5_sum_d, n5_sum_q;
  aar_pkg::aar_sq_side_t n5_side_d, n5_side_q;
  logic                  n5_vld_q;

  always_comb begin
    n5_sum_d      = n4_sq_q[0] + n4_sq_q[1] + n4_sq_q[2];
    n5_side_d.ctl = n4_ctl_q;
    for (int k = 0; k < 3; k++) begin
      n5_side_d.mag[k] = n4_mag_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_vld_q <= 1'b0;
      n2_vld_q <= 1'b0;
      n3_vld_q <= 1'b0;
      n4_vld_q <= 1'b0;
      n5_vld_q <= 1'b0;
    end else begin
      n1_vld_q <= co_vld;
      n2_vld_q <= n1_vld_q;
      n3_vld_q <= n2_vld_q;
      n4_vld_q <= n3_vld_q;
      n5_vld_q <= n4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_mag_q  <= n1_mag_d;
    n1_max_q  <= n1_max_d;
    n1_ctl_q  <= n1_ctl_d;
    n2_k_q    <= n2_k_d;
    n2_mag_q  <= n1_mag_q;
    n2_ctl_q  <= n1_ctl_q;
    n3_mag_q  <= n3_mag_d;
    n3_ctl_q  <= n2_ctl_q;
    n4_sq_q   <= n4_sq_d;
    n4_mag_q  <= n3_mag_q;
    n4_ctl_q  <= n3_ctl_q;
    n5_sum_q  <= n5_sum_d;
    n5_side_q <= n5_side_d;
  end

  // Norm of the axis
  logic                         sq_vld;
  logic [aar_pkg::RW-1:0]       sq_root;
  aar_pkg::aar_sq_side_t        sq_side;

  aar_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n5_vld_q),
    .rad_i   (n5_sum_q),
    .side_i  (n5_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Unit axis
  logic                          dv_vld;
  logic [2:0][aar_pkg::QW-1:0]   dv_quo;
  aar_pkg::aar_ctl_t             dv_ctl;

  aar_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .root_i  (sq_root),
    .mag_i   (sq_side.mag),
    .ctl_i   (sq_side.ctl),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .ctl_o   (dv_ctl)
  );

  // Matrix entries
  logic [8:0][FRAC_BITS+1:0] rod_r;

  aar_rod #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_vld),
    .quo_i   (dv_quo),
    .ctl_i   (dv_ctl),
    .valid_o (valid_o),
    .r_o     (rod_r),
    .zero_o  (zero_axis_o)
  );

  assign r00_o = rod_r[0];
  assign r01_o = rod_r[1];
  assign r02_o = rod_r[2];
  assign r10_o = rod_r[3];
  assign r11_o = rod_r[4];
  assign r12_o = rod_r[5];
  assign r20_o = rod_r[6];
  assign r21_o = rod_r[7];
  assign r22_o = rod_r[8];

endmodule

`default_nettype wire

/* rtl/aar_checker.sv */
`default_nettype none

// Port-level checks on the result stream
module aar_checker #(
  parameter int FRAC_BITS = aar_pkg::FRAC_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        busy,
  input logic                        valid_o,
  input logic signed [FRAC_BITS+1:0] r00_o,
  input logic signed [FRAC_BITS+1:0] r01_o,
  input logic signed [FRAC_BITS+1:0] r02_o,
  input logic signed [FRAC_BITS+1:0] r10_o,
  input logic signed [FRAC_BITS+1:0] r11_o,
  input logic signed [FRAC_BITS+1:0] r12_o,
  input logic signed [FRAC_BITS+1:0] r20_o,
  input logic signed [FRAC_BITS+1:0] r21_o,
  input logic signed [FRAC_BITS+1:0] r22_o,
  input logic                        zero_axis_o
);

  localparam int OUT_W = FRAC_BITS + 2;
  localparam logic signed [OUT_W-1:0] LIM = OUT_W'(64'sd1 <<< FRAC_BITS);

  logic all_in_range;
  logic off_diag_zero;

  assign all_in_range =
    (r00_o <= LIM) && (r00_o >= -LIM) && (r01_o <= LIM) && (r01_o >= -LIM) &&
    (r02_o <= LIM) && (r02_o >= -LIM) && (r10_o <= LIM) && (r10_o >= -LIM) &&
    (r11_o <= LIM) && (r11_o >= -LIM) && (r12_o <= LIM) && (r12_o >= -LIM) &&
    (r20_o <= LIM) && (r20_o >= -LIM) && (r21_o <= LIM) && (r21_o >= -LIM) &&
    (r22_o <= LIM) && (r22_o >= -LIM);

  assign off_diag_zero = (r01_o == '0) && (r02_o == '0) && (r10_o == '0) &&
                         (r12_o == '0) && (r20_o == '0) && (r21_o == '0);

  // No item can come out right after reset
  a_no_result_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !valid_o)
    else $error("result strobe right after reset");

  // Pipeline takes an item every cycle
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  // Zero axis gives cos times identity
  a_zero_axis_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && zero_axis_o) |-> (off_diag_zero && (r00_o == r11_o) && (r11_o == r22_o)))
    else $error("zero-axis result is not a scaled identity");

  // Every entry clamped to +/-1
  a_entries_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> all_in_range)
    else $error("matrix entry outside +/-1");

endmodule

bind axis_angle_to_rotation_matrix aar_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_aar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy        (busy),
  .valid_o     (valid_o),
  .r00_o       (r00_o),
  .r01_o       (r01_o),
  .r02_o       (r02_o),
  .r10_o       (r10_o),
  .r11_o       (r11_o),
  .r12_o       (r12_o),
  .r20_o       (r20_o),
  .r21_o       (r21_o),
  .r22_o       (r22_o),
  .zero_axis_o (zero_axis_o)
);

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;

  localparam int AW = aar_pkg::AXIS_WIDTH_DEF;
  localparam int GW = aar_pkg::ANGLE_WIDTH_DEF;
  localparam int FB = aar_pkg::FRAC_BITS_DEF;
  localparam int QI = aar_pkg::QI;
  localparam int OW = FB + 2;
  localparam int PIPE_LAT = 104;

  typedef struct packed {
    logic signed [AW-1:0] ax;
    logic signed [AW-1:0] ay;
    logic signed [AW-1:0] az;
    logic signed [GW-1:0] ang;
  } pose_t;

  typedef struct {
    logic signed [OW-1:0] r [9];
    logic                 zero;
  } rot_t;

  logic clk_i, rst_ni, start, busy, valid_o, zero_axis_o;
  logic signed [AW-1:0] axis_x_i, axis_y_i, axis_z_i;
  logic signed [GW-1:0] turn_angle_i;
  logic signed [OW-1:0] r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  rot_t pending_rots[$];
  int   mismatches = 0;
  int   send_idle_pct = 0;

  axis_angle_to_rotation_matrix uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .axis_x_i(axis_x_i), .axis_y_i(axis_y_i), .axis_z_i(axis_z_i),
    .turn_angle_i(turn_angle_i), .valid_o(valid_o),
    .r00_o(r00_o), .r01_o(r01_o), .r02_o(r02_o), .r10_o(r10_o), .r11_o(r11_o),
    .r12_o(r12_o), .r20_o(r20_o), .r21_o(r21_o), .r22_o(r22_o),
    .zero_axis_o(zero_axis_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Fixed-point helpers, floor shifts on 64-bit signed
  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< (QI - 1))) >>> QI;
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // CORDIC cos/sin in Q.30, quadrant folded
  function automatic void cordic_sincos(input logic [GW-1:0] ang, output longint c,
                                        output longint s);
    logic [31:0] ph;
    longint x, y, z, xn, cc, ss;
    ph = {ang, {(32 - GW){1'b0}}};
    x = aar_pkg::CORDIC_X0;
    y = 0;
    z = longint'(ph[29:0]);
    for (int i = 0; i < aar_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(aar_pkg::ATAN_TAB[i]);
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(aar_pkg::ATAN_TAB[i]);
      end
      x = xn;
    end
    cc = sat(x, 64'sd1 <<< QI);
    ss = sat(y, 64'sd1 <<< QI);
    case (ph[31:30])
      2'd0: begin c = cc;  s = ss;  end
      2'd1: begin c = -ss; s = cc;  end
      2'd2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endfunction

  // Rodrigues rotation matrix for one pose
  function automatic rot_t rodrigues(pose_t p);
    rot_t o;
    longint c, s, t, n, q, v[3], u[3], e[9];
    longint unsigned mag[3], m, sum;
    int k;
    cordic_sincos(p.ang, c, s);
    v[0] = p.ax; v[1] = p.ay; v[2] = p.az;
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    for (int i = 0; i < 9; i++) e[i] = 0;
    if (m == 0) begin
      e[0] = c; e[4] = c; e[8] = c;
      o.zero = 1'b1;
    end else begin
      k = 0;
      while ((m << k) < (64'd1 << QI)) k++;
      for (int i = 0; i < 3; i++) begin
        mag[i] <<= k;
        sum += mag[i] * mag[i];
      end
      n = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = longint'(((mag[i] << (QI + 1)) + n) / (2 * n));
        u[i] = (v[i] < 0) ? -q : q;
      end
      t = (64'sd1 <<< QI) - c;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) e[i*3+j] = qmul(t, qmul(u[i], u[j]));
      e[0] += c; e[4] += c; e[8] += c;
      e[1] -= qmul(s, u[2]); e[2] += qmul(s, u[1]);
      e[3] += qmul(s, u[2]); e[5] -= qmul(s, u[0]);
      e[6] -= qmul(s, u[1]); e[7] += qmul(s, u[0]);
      o.zero = 1'b0;
    end
    for (int i = 0; i < 9; i++)
      o.r[i] = OW'(sat((e[i] + (64'sd1 <<< (QI - FB - 1))) >>> (QI - FB), 64'sd1 <<< FB));
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Send one item; start is held across back-to-back items
  task automatic send_pose(input pose_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start        <= 1'b1;
    axis_x_i     <= p.ax;
    axis_y_i     <= p.ay;
    axis_z_i     <= p.az;
    turn_angle_i <= p.ang;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_rots.push_back(rodrigues(p));
    @(negedge clk_i);
  endtask

  task automatic idle_line();
    start <= 1'b0;
  endtask

  function automatic pose_t mk(int x, int y, int z, int a);
    pose_t p;
    p.ax = AW'(x); p.ay = AW'(y); p.az = AW'(z); p.ang = GW'(a);
    return p;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    logic signed [OW-1:0] got [9];
    rot_t want;
    if (rst_ni && valid_o) begin
      got = '{r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o};
      if (pending_rots.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = pending_rots.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== want.r[i]) report_mismatch($sformatf("r%0d%0d", i / 3, i % 3),
                                                    got[i], want.r[i]);
        if (zero_axis_o !== want.zero) report_mismatch("zero_axis", zero_axis_o, want.zero);
      end
    end
  end

  // Axis and angle extremes, zero axis, angle wrap, full-scale negative axis
  task automatic test_directed();
    send_pose(mk(0, 0, 0, 0));
    send_pose(mk(0, 0, 0, 16384));
    send_pose(mk(0, 0, 0, -32768));
    send_pose(mk(1, 0, 0, 16384));
    send_pose(mk(0, 1, 0, -16384));
    send_pose(mk(0, 0, 1, 8192));
    send_pose(mk(-32768, 0, 0, 32767));
    send_pose(mk(-32768, -32768, -32768, -32768));
    send_pose(mk(32767, 32767, 32767, 32767));
    send_pose(mk(-32768, 32767, 0, 1));
    send_pose(mk(-1, -1, -1, -1));
    send_pose(mk(1, 1, 1, 0));
    send_pose(mk(100, -200, 300, 21845));
    send_pose(mk(0, -32768, 1, 16383));
    send_pose(mk(32767, 0, -32768, -16385));
    send_pose(mk(0, 0, -5, 24576));
    send_pose(mk(3, 4, 0, -24576));
    idle_line();
  endtask

  function automatic int rnd_axis();
    case ($urandom_range(5))
      0: return 0;
      1: return $urandom_range(1) ? -32768 : 32767;
      2: return int'($urandom_range(16)) - 8;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic test_random(input int count, input int idle_pct);
    pose_t p;
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      p = mk(rnd_axis(), rnd_axis(), rnd_axis(), int'($urandom_range(65535)));
      if ($urandom_range(49) == 0) p = mk(0, 0, 0, int'($urandom_range(65535)));
      send_pose(p);
    end
    idle_line();
    send_idle_pct = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    axis_x_i = '0;
    axis_y_i = '0;
    axis_z_i = '0;
    turn_angle_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(300, 14);
    test_random(300, 66);
    test_random(300, 0);
    while (pending_rots.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 20) @(posedge clk_i);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
